FILE: src/pba_pkg.sv
`timescale 1ns / 1ps
// Page bitmap allocator: shared types and codes.
// No dependencies; used by the channel interfaces and the top level.
package pba_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 13;

	typedef enum logic [1:0] {
		CMD_ALLOC     = 2'd0,
		CMD_FREE      = 2'd1,
		CMD_MARK_USED = 2'd2,
		CMD_MARK_FREE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_MEM   = 2'd1,
		ST_BAD_ADDR = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] length_bytes;
	} req_beat_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  page_addr;
		status_t            status;
		logic [COUNT_W-1:0] free_count;
	} rsp_beat_t;

endpackage

FILE: src/pba_req_if.sv
`timescale 1ns / 1ps
// Command channel: valid/ready handshake carrying one command beat.
// Depends on pba_pkg.
interface pba_req_if;
	logic               valid;
	logic               ready;
	pba_pkg::req_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/pba_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one result beat.
// Depends on pba_pkg.
interface pba_rsp_if;
	logic               valid;
	logic               ready;
	pba_pkg::rsp_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/page_bitmap_allocator.sv
`timescale 1ns / 1ps
// First-fit page allocator over a one-bit-per-page usage bitmap held in RAM.
// Depends on pba_pkg, pba_req_if, pba_rsp_if.
//
//   channel  dir  beat                                   handshake
//   req      in   cmd, start_addr, length_bytes          valid/ready
//   rsp      out  page_addr, status, free_count          valid/ready
//
// Allocate scans the bitmap words in order until it finds a free page, or to the
// end when full. Free and mark range walk the words they touch; an empty range or
// out-of-range free skips the walk. Byte-to-page and page-to-word splits are shifts, so
// the user must keep PAGE_BYTES and WORD_BITS powers of two; nothing here enforces it.
// After reset a fill pass marks every page used; req is held off meanwhile.
// A held response beat stalls the next command only at its own result.
module page_bitmap_allocator #(
	parameter int NUM_PAGES  = 4096,
	parameter int PAGE_BYTES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	pba_req_if.sink   req,
	pba_rsp_if.source rsp
);

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW        = $clog2(NUM_PAGES);
	localparam int CW        = $clog2(NUM_PAGES + 1);
	localparam int PSW       = CW + 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int FW        = $clog2(WORD_BITS + 1);
	localparam int PGS       = $clog2(PAGE_BYTES);
	localparam int PBW       = $clog2(PAGE_BYTES + 1);
	localparam int PRW       = PW + PBW;
	localparam int SW        = pba_pkg::ADDR_W + 2;

	typedef enum logic [6:0] {
		S_INIT = 7'b000_0001,
		S_IDLE = 7'b000_0010,
		S_PREP = 7'b000_0100,
		S_SCAN = 7'b000_1000,
		S_WALK = 7'b001_0000,
		S_CNT  = 7'b010_0000,
		S_FIN  = 7'b100_0000
	} state_t;

	state_t state_q, state_d;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_s1;

	logic [WIW-1:0]  init_q;
	logic [CW-1:0]   count_q;
	logic            out_valid_q;
	pba_pkg::rsp_beat_t out_q;

	pba_pkg::cmd_t   cmd_q;
	logic [pba_pkg::ADDR_W-1:0] base_q, len_q;
	pba_pkg::status_t status_q;
	logic [pba_pkg::ADDR_W-1:0] addr_q;

	logic [CW-1:0]   first_q;
	logic [CW-1:0]   last_q;
	logic [WIW-1:0]  w_q, w_s1;
	logic [PSW-1:0]  ps_q, ps_s1;
	logic            issued_last_q, last_s1, v_s1;
	logic            v_s2, dir_s2;
	logic [FW-1:0]   cnt_s2;
	logic [PW-1:0]   pidx_q;

	logic            accept, fin_take, issue, issue_end, active, proc;
	logic            used_dir, hit, found, scan_miss;
	logic [WORD_BITS-1:0] zeros, pick, mask, flips, wd;
	logic [BW-1:0]   idx;
	logic [PSW-1:0]  lo_off, hi_off;
	logic [FW-1:0]   pop;
	logic            mem_we;
	logic [WIW-1:0]  mem_wa;
	logic [WORD_BITS-1:0] mem_wd;

	logic [pba_pkg::ADDR_W-1:0] pg_first;
	logic [SW-1:0]   end_sum, pg_end;
	logic            first_ovf;
	logic [CW-1:0]   first_clip, last_clip, range_end;
	logic            rng_empty;
	logic [PRW-1:0]  prod;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign fin_take  = (state_q == S_FIN) && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// page bounds of the command, clipped at NUM_PAGES
	assign pg_first   = base_q >> PGS;
	assign end_sum    = SW'(base_q) + SW'(len_q) + SW'(PAGE_BYTES - 1);
	assign pg_end     = end_sum >> PGS;
	assign first_ovf  = (pg_first >= pba_pkg::ADDR_W'(NUM_PAGES));
	assign first_clip = first_ovf ? CW'(NUM_PAGES) : CW'(pg_first);
	assign last_clip  = (pg_end > SW'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(pg_end);
	assign range_end  = (cmd_q == pba_pkg::CMD_FREE) ? first_clip + CW'(1) : last_clip;
	assign rng_empty  = first_ovf || (first_clip >= range_end);
	assign prod       = PRW'(pidx_q) * PRW'(PAGE_BYTES);

	assign active    = (state_q == S_SCAN) || (state_q == S_WALK);
	assign issue     = active && !issued_last_q;
	assign issue_end = (state_q == S_SCAN) ? (w_q == WIW'(MAP_WORDS - 1))
	                                       : (ps_q + PSW'(WORD_BITS) >= PSW'(last_q));
	assign proc      = v_s1 && active;
	assign used_dir  = (cmd_q == pba_pkg::CMD_ALLOC) || (cmd_q == pba_pkg::CMD_MARK_USED);

	assign zeros     = ~rd_s1;
	assign hit       = |zeros;
	assign pick      = zeros & (~zeros + WORD_BITS'(1));
	assign found     = proc && (state_q == S_SCAN) && hit;
	assign scan_miss = proc && (state_q == S_SCAN) && !hit && last_s1;

	assign lo_off = (PSW'(first_q) > ps_s1) ? PSW'(first_q) - ps_s1 : '0;
	assign hi_off = PSW'(last_q) - ps_s1;

	always_comb begin
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (zeros[i]) begin
				idx = BW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = (PSW'(i) >= lo_off) && (PSW'(i) < hi_off);
		end
	end

	always_comb begin
		if (state_q == S_SCAN) begin
			wd    = rd_s1 | pick;
			flips = pick;
		end else if (used_dir) begin
			wd    = rd_s1 | mask;
			flips = mask & ~rd_s1;
		end else begin
			wd    = rd_s1 & ~mask;
			flips = mask & rd_s1;
		end
	end

	always_comb begin
		pop = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			pop = pop + FW'(flips[i]);
		end
	end

	always_comb begin
		if (state_q == S_INIT) begin
			mem_we = 1'b1;
			mem_wa = init_q;
			mem_wd = '1;
		end else begin
			mem_we = proc && ((state_q == S_WALK) || found);
			mem_wa = w_s1;
			mem_wd = wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rd_s1 <= mem[w_q];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: if (init_q == WIW'(MAP_WORDS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					state_d = (req.data.cmd == pba_pkg::CMD_ALLOC) ? S_SCAN : S_PREP;
				end
			end
			S_PREP: state_d = rng_empty ? S_FIN : S_WALK;
			S_SCAN, S_WALK: if (proc && (found || last_s1)) state_d = S_CNT;
			S_CNT:  state_d = S_FIN;
			S_FIN:  if (fin_take) state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			init_q        <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
			issued_last_q <= 1'b0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				init_q <= init_q + WIW'(1);
			end
			if (accept) begin
				issued_last_q <= 1'b0;
			end else if (issue && issue_end) begin
				issued_last_q <= 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= proc;
			if (v_s2) begin
				count_q <= dir_s2 ? count_q - CW'(cnt_s2) : count_q + CW'(cnt_s2);
			end
			if (fin_take) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.data.cmd;
			base_q   <= req.data.start_addr;
			len_q    <= req.data.length_bytes;
			status_q <= pba_pkg::ST_OK;
			addr_q   <= '0;
			w_q      <= '0;
			ps_q     <= '0;
		end
		if (state_q == S_PREP) begin
			first_q <= first_clip;
			last_q  <= range_end;
			w_q     <= WIW'(first_clip >> BW);
			ps_q    <= PSW'(first_clip) & ~PSW'(WORD_BITS - 1);
			if ((cmd_q == pba_pkg::CMD_FREE) && first_ovf) begin
				status_q <= pba_pkg::ST_BAD_ADDR;
			end
		end
		if (issue) begin
			w_q     <= w_q + WIW'(1);
			ps_q    <= ps_q + PSW'(WORD_BITS);
			w_s1    <= w_q;
			ps_s1   <= ps_q;
			last_s1 <= issue_end;
		end
		if (proc) begin
			cnt_s2 <= pop;
			dir_s2 <= used_dir;
		end
		if (found) begin
			pidx_q <= PW'(ps_s1 + PSW'(idx));
		end
		if (scan_miss) begin
			status_q <= pba_pkg::ST_NO_MEM;
		end
		if ((state_q == S_CNT) && (cmd_q == pba_pkg::CMD_ALLOC)
		    && (status_q == pba_pkg::ST_OK)) begin
			addr_q <= pba_pkg::ADDR_W'(prod);
		end
		if (fin_take) begin
			out_q.page_addr  <= addr_q;
			out_q.status     <= status_q;
			out_q.free_count <= pba_pkg::COUNT_W'(count_q);
		end
	end

endmodule
